>>> sv/assert_macros.svh
// ============================================================================
// Assertion macros
// Wrappers for the concurrent assertions of the pixel blit design.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define PFB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pfb assertion failed");

// Next-cycle implication, checked at each rising clock edge outside reset.
`define PFB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pfb assertion failed");

`endif

>>> sv/pfb_pkg.sv
// ============================================================================
// pfb_pkg
// Types, constants and helper functions shared by the pixel blit modules.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pfb_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = $clog2(MAX_DIM) + 1;
    localparam int CNT_W      = $clog2(MAX_DIM);
    localparam int FMT_W      = 3;
    localparam int CHAN_W     = 8;
    localparam int OFFSET_W   = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH) + 1;

    // Gray is floor(sum / 3) with sum <= 765; (sum * 683) >> 11 is exact there.
    localparam int SUM_W       = 10;
    localparam int GRAY_RECIP  = 683;
    localparam int GRAY_SHIFT  = 11;
    localparam int PROD_W      = 20;

    // Pixel format codes (bytes per pixel).
    localparam logic [FMT_W-1:0] FMT_GRAY       = 3'd1;
    localparam logic [FMT_W-1:0] FMT_GRAY_ALPHA = 3'd2;
    localparam logic [FMT_W-1:0] FMT_RGB        = 3'd3;
    localparam logic [FMT_W-1:0] FMT_RGBA       = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SRC_FORMAT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DST_FORMAT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_COL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_ROW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 3'd7;

    localparam logic [CHAN_W-1:0] OPAQUE_ALPHA = 8'd255;

    // One classified pixel, as the front hands it to the back.
    typedef struct packed {
        logic [CHAN_W-1:0] chan0;
        logic [CHAN_W-1:0] chan1;
        logic [CHAN_W-1:0] chan2;
        logic [CHAN_W-1:0] chan3;
        logic [FMT_W-1:0]  src_fmt;
        logic [FMT_W-1:0]  dst_fmt;
        logic [DIM_W-1:0]  x;
        logic [DIM_W-1:0]  y;
        logic [DIM_W-1:0]  dw;
        logic              oob;
        logic              last;
    } q_entry_t;

    typedef struct packed {
        logic     push;
        q_entry_t entry;
    } q_wr_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_rd_t;

    function automatic logic [FMT_W-1:0] eff_format(input logic [FMT_W-1:0] f);
        logic [FMT_W-1:0] r;
        case (f) inside
            3'd0:          r = FMT_GRAY;
            [3'd5:3'd7]:   r = FMT_RGBA;
            default:       r = f;
        endcase
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] s);
        logic [DIM_W-1:0] r;
        if (s == '0) begin
            r = DIM_W'(1);
        end else if (s > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = s;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/pfb_front.sv
// ============================================================================
// pfb_front
// Holds configuration and the rectangle position, classifies each item.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pfb_front import pfb_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [CHAN_W-1:0]     s_chan0,
    input  wire logic [CHAN_W-1:0]     s_chan1,
    input  wire logic [CHAN_W-1:0]     s_chan2,
    input  wire logic [CHAN_W-1:0]     s_chan3,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  q_ready,
    output q_wr_t                      q_wr
);

    logic [FMT_W-1:0] src_format_reg, dst_format_reg;
    logic [DIM_W-1:0] rect_width_reg, rect_height_reg;
    logic [CNT_W-1:0] dest_col_reg, dest_row_reg;
    logic [DIM_W-1:0] dest_width_reg, dest_height_reg;
    logic [CNT_W-1:0] col_count_reg, col_count_next;
    logic [CNT_W-1:0] row_count_reg, row_count_next;

    logic [DIM_W-1:0] rw, rh, dw, dh, x, y;
    logic             end_row, final_px, oob, accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = q_ready;
    assign accept    = s_valid & q_ready;

    assign rw = eff_size(rect_width_reg);
    assign rh = eff_size(rect_height_reg);
    assign dw = eff_size(dest_width_reg);
    assign dh = eff_size(dest_height_reg);

    assign x = {1'b0, dest_col_reg} + {1'b0, col_count_reg};
    assign y = {1'b0, dest_row_reg} + {1'b0, row_count_reg};

    assign oob      = (x >= dw) || (y >= dh);
    assign end_row  = (({1'b0, col_count_reg} + DIM_W'(1)) >= rw);
    assign final_px = end_row && (({1'b0, row_count_reg} + DIM_W'(1)) >= rh);

    always_comb begin
        q_wr.push          = accept;
        q_wr.entry.chan0   = s_chan0;
        q_wr.entry.chan1   = s_chan1;
        q_wr.entry.chan2   = s_chan2;
        q_wr.entry.chan3   = s_chan3;
        q_wr.entry.src_fmt = eff_format(src_format_reg);
        q_wr.entry.dst_fmt = eff_format(dst_format_reg);
        q_wr.entry.x       = x;
        q_wr.entry.y       = y;
        q_wr.entry.dw      = dw;
        q_wr.entry.oob     = oob;
        q_wr.entry.last    = final_px;
    end

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept) begin
            if (final_px) begin
                col_count_next = '0;
                row_count_next = '0;
            end else if (end_row) begin
                col_count_next = '0;
                row_count_next = row_count_reg + CNT_W'(1);
            end else begin
                col_count_next = col_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_format_reg  <= FMT_RGBA;
            dst_format_reg  <= FMT_RGBA;
            rect_width_reg  <= DIM_W'(1);
            rect_height_reg <= DIM_W'(1);
            dest_col_reg    <= '0;
            dest_row_reg    <= '0;
            dest_width_reg  <= DIM_W'(1);
            dest_height_reg <= DIM_W'(1);
            col_count_reg   <= '0;
            row_count_reg   <= '0;
        end else begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_SRC_FORMAT:  src_format_reg  <= cfg_data[FMT_W-1:0];
                    REG_DST_FORMAT:  dst_format_reg  <= cfg_data[FMT_W-1:0];
                    REG_RECT_WIDTH:  rect_width_reg  <= cfg_data[DIM_W-1:0];
                    REG_RECT_HEIGHT: rect_height_reg <= cfg_data[DIM_W-1:0];
                    REG_DEST_COL:    dest_col_reg    <= cfg_data[CNT_W-1:0];
                    REG_DEST_ROW:    dest_row_reg    <= cfg_data[CNT_W-1:0];
                    REG_DEST_WIDTH:  dest_width_reg  <= cfg_data[DIM_W-1:0];
                    REG_DEST_HEIGHT: dest_height_reg <= cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/pfb_queue.sv
// ============================================================================
// pfb_queue
// Short first-in first-out buffer between the front and the back.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pfb_queue import pfb_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire q_wr_t q_wr,
    output logic       q_ready,
    output q_rd_t      q_rd,
    input  wire logic  q_pop
);

    q_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_ready       = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_rd.valid    = (count_reg != '0);
    assign q_rd.entry    = slot_reg[rd_ptr_reg];
    assign do_push       = q_wr.push;
    assign do_pop        = q_pop;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= q_wr.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    `PFB_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `PFB_ASSERT_IMP(a_no_push_full, aclk, aresetn, do_push, count_reg != QCNT_W'(QUEUE_DEPTH))
    `PFB_ASSERT_IMP(a_no_pop_empty, aclk, aresetn, do_pop, count_reg != '0)
    `PFB_ASSERT_NXT(a_push_grows, aclk, aresetn, do_push && !do_pop, count_reg == $past(count_reg) + QCNT_W'(1))

endmodule

`default_nettype wire

>>> sv/pfb_back.sv
// ============================================================================
// pfb_back
// Converts the pixel format and computes the destination byte offset.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pfb_back import pfb_pkg::*; (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire q_rd_t          q_rd,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [OFFSET_W-1:0] m_dest_offset,
    output logic [CHAN_W-1:0]   m_out_chan0,
    output logic [CHAN_W-1:0]   m_out_chan1,
    output logic [CHAN_W-1:0]   m_out_chan2,
    output logic [CHAN_W-1:0]   m_out_chan3,
    output logic [FMT_W-1:0]    m_out_bytes,
    output logic                m_out_of_range,
    output logic                m_last
);

    // First stage: gray reduction, source unpacking, linear pixel index.
    logic                a_valid_reg;
    logic [CHAN_W-1:0]   a_gray_reg, a_r_reg, a_g_reg, a_b_reg, a_alpha_reg;
    logic [FMT_W-1:0]    a_df_reg;
    logic                a_oob_reg, a_last_reg;
    logic [OFFSET_W-1:0] a_lin_reg;

    // Second stage is the output register.
    logic                m_valid_reg;
    logic [OFFSET_W-1:0] m_offset_reg;
    logic [CHAN_W-1:0]   m_c0_reg, m_c1_reg, m_c2_reg, m_c3_reg;
    logic [FMT_W-1:0]    m_bytes_reg;
    logic                m_oob_reg, m_last_reg;

    logic                b_en, a_en;
    logic                color;
    logic [SUM_W-1:0]    sum;
    logic [PROD_W-1:0]   prod;
    logic [CHAN_W-1:0]   gray_d, g_d, b_d, alpha_d;
    logic [2*DIM_W-1:0]  idx_prod;
    logic [OFFSET_W-1:0] lin_d;
    logic [CHAN_W-1:0]   o0, o1, o2, o3;
    logic [OFFSET_W-1:0] offset_d;

    assign b_en  = !m_valid_reg || m_ready;
    assign a_en  = !a_valid_reg || b_en;
    assign q_pop = q_rd.valid && a_en;

    always_comb begin
        color  = (q_rd.entry.src_fmt >= FMT_RGB);
        sum    = SUM_W'(q_rd.entry.chan0) + SUM_W'(q_rd.entry.chan1)
               + SUM_W'(q_rd.entry.chan2);
        prod   = PROD_W'(sum) * PROD_W'(GRAY_RECIP);
        gray_d = color ? prod[GRAY_SHIFT +: CHAN_W] : q_rd.entry.chan0;
        g_d    = color ? q_rd.entry.chan1 : q_rd.entry.chan0;
        b_d    = color ? q_rd.entry.chan2 : q_rd.entry.chan0;
        if (q_rd.entry.src_fmt == FMT_GRAY_ALPHA) begin
            alpha_d = q_rd.entry.chan1;
        end else if (q_rd.entry.src_fmt == FMT_RGBA) begin
            alpha_d = q_rd.entry.chan3;
        end else begin
            alpha_d = OPAQUE_ALPHA;
        end
        // The full product of row and width, then the index wraps at 2^26
        // just as the offset does.
        idx_prod = q_rd.entry.y * q_rd.entry.dw;
        lin_d    = OFFSET_W'(idx_prod) + OFFSET_W'(q_rd.entry.x);
    end

    always_comb begin
        o0 = a_r_reg;
        o1 = '0;
        o2 = '0;
        o3 = '0;
        offset_d = a_lin_reg;
        unique case (a_df_reg)
            FMT_GRAY: begin
                o0 = a_gray_reg;
            end
            FMT_GRAY_ALPHA: begin
                o0 = a_gray_reg;
                o1 = a_alpha_reg;
                offset_d = a_lin_reg << 1;
            end
            FMT_RGB: begin
                o1 = a_g_reg;
                o2 = a_b_reg;
                offset_d = a_lin_reg + (a_lin_reg << 1);
            end
            default: begin
                o1 = a_g_reg;
                o2 = a_b_reg;
                o3 = a_alpha_reg;
                offset_d = a_lin_reg << 2;
            end
        endcase
        if (a_oob_reg) begin
            offset_d = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_gray_reg  <= gray_d;
            a_r_reg     <= q_rd.entry.chan0;
            a_g_reg     <= g_d;
            a_b_reg     <= b_d;
            a_alpha_reg <= alpha_d;
            a_df_reg    <= q_rd.entry.dst_fmt;
            a_oob_reg   <= q_rd.entry.oob;
            a_last_reg  <= q_rd.entry.last;
            a_lin_reg   <= lin_d;
        end
        if (b_en) begin
            m_offset_reg <= offset_d;
            m_c0_reg     <= o0;
            m_c1_reg     <= o1;
            m_c2_reg     <= o2;
            m_c3_reg     <= o3;
            m_bytes_reg  <= a_df_reg;
            m_oob_reg    <= a_oob_reg;
            m_last_reg   <= a_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_en) begin
                a_valid_reg <= q_rd.valid;
            end
            if (b_en) begin
                m_valid_reg <= a_valid_reg;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_dest_offset  = m_offset_reg;
    assign m_out_chan0    = m_c0_reg;
    assign m_out_chan1    = m_c1_reg;
    assign m_out_chan2    = m_c2_reg;
    assign m_out_chan3    = m_c3_reg;
    assign m_out_bytes    = m_bytes_reg;
    assign m_out_of_range = m_oob_reg;
    assign m_last         = m_last_reg;

endmodule

`default_nettype wire

>>> sv/pixel_format_blit.sv
// ============================================================================
// pixel_format_blit
// Rectangle blit with pixel format conversion, one pixel per item.
// ============================================================================
//
//   Channel   Direction  Handshake              Payload
//   s_        in         s_valid / s_ready      s_chan0..s_chan3 source bytes
//   m_        out        m_valid / m_ready      offset, out_chan0..3, bytes, flags
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Throughput is one item per clock when the result side keeps m_ready high.
// An accepted item passes through the four-entry queue, then the conversion
// stage and the output register.
// The conversion stage holds the one 13x13 multiply for the pixel index.
// Reset clears the rectangle position, loads the register defaults and empties
// the queue and the back stages. Configuration writes are taken in any cycle.
// When m_ready is low the back stages fill, then the queue, then s_ready falls.
//
`timescale 1ns / 1ps
`default_nettype none

module pixel_format_blit import pfb_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [CHAN_W-1:0]     s_chan0,
    input  wire logic [CHAN_W-1:0]     s_chan1,
    input  wire logic [CHAN_W-1:0]     s_chan2,
    input  wire logic [CHAN_W-1:0]     s_chan3,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [OFFSET_W-1:0]        m_dest_offset,
    output logic [CHAN_W-1:0]          m_out_chan0,
    output logic [CHAN_W-1:0]          m_out_chan1,
    output logic [CHAN_W-1:0]          m_out_chan2,
    output logic [CHAN_W-1:0]          m_out_chan3,
    output logic [FMT_W-1:0]           m_out_bytes,
    output logic                       m_out_of_range,
    output logic                       m_last,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // The front writes classified items into the queue; the back drains it.
    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_ready;
    logic  q_pop;

    // The front owns the registers and the rectangle position. Each accepted
    // item leaves with its destination coordinates, bounds flag and last flag
    // already settled, so a later register write cannot disturb it.
    pfb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_chan0   (s_chan0),
        .s_chan1   (s_chan1),
        .s_chan2   (s_chan2),
        .s_chan3   (s_chan3),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_ready   (q_ready),
        .q_wr      (q_wr)
    );

    // The queue lets the front keep taking items while the result side stalls.
    pfb_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .q_ready (q_ready),
        .q_rd    (q_rd),
        .q_pop   (q_pop)
    );

    // The back performs the format conversion and the offset arithmetic, and
    // its output register holds a finished result until it is taken.
    pfb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_rd           (q_rd),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dest_offset  (m_dest_offset),
        .m_out_chan0    (m_out_chan0),
        .m_out_chan1    (m_out_chan1),
        .m_out_chan2    (m_out_chan2),
        .m_out_chan3    (m_out_chan3),
        .m_out_bytes    (m_out_bytes),
        .m_out_of_range (m_out_of_range),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for pixel_format_blit. The bench writes the blit
// registers while the block is idle. It streams source pixels through the
// s_ channel and follows each accepted pixel with its own conversion and
// addressing rules. Every result on the m_ channel is checked field by field
// against the oldest pending conversion.
// ============================================================================

module testbench;
    import pfb_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_PCT      = 17;      // chance in a hundred that a side idles
    localparam int SETTLE_CYCLES = 10;      // settling margin once every result is out
    localparam int RANDOM_ITEMS  = 1100;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int MAX_PRINTED   = 40;

    // One source pixel as it travels on the s_ channel.
    typedef struct packed {
        logic [CHAN_W-1:0] c0;
        logic [CHAN_W-1:0] c1;
        logic [CHAN_W-1:0] c2;
        logic [CHAN_W-1:0] c3;
    } pixel_t;

    // One converted pixel, in the same order as the m_ ports.
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [CHAN_W-1:0]   c0;
        logic [CHAN_W-1:0]   c1;
        logic [CHAN_W-1:0]   c2;
        logic [CHAN_W-1:0]   c3;
        logic [FMT_W-1:0]    nbytes;
        logic                oob;
        logic                last;
    } converted_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CHAN_W-1:0]     s_chan0 = '0;
    logic [CHAN_W-1:0]     s_chan1 = '0;
    logic [CHAN_W-1:0]     s_chan2 = '0;
    logic [CHAN_W-1:0]     s_chan3 = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OFFSET_W-1:0]   m_dest_offset;
    logic [CHAN_W-1:0]     m_out_chan0;
    logic [CHAN_W-1:0]     m_out_chan1;
    logic [CHAN_W-1:0]     m_out_chan2;
    logic [CHAN_W-1:0]     m_out_chan3;
    logic [FMT_W-1:0]      m_out_bytes;
    logic                  m_out_of_range;
    logic                  m_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    pixel_format_blit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_chan0        (s_chan0),
        .s_chan1        (s_chan1),
        .s_chan2        (s_chan2),
        .s_chan3        (s_chan3),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dest_offset  (m_dest_offset),
        .m_out_chan0    (m_out_chan0),
        .m_out_chan1    (m_out_chan1),
        .m_out_chan2    (m_out_chan2),
        .m_out_chan3    (m_out_chan3),
        .m_out_bytes    (m_out_bytes),
        .m_out_of_range (m_out_of_range),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------
    pixel_t     source_pixels[$];       // pixels waiting for the driver
    converted_t converted_pixels[$];    // predicted results, oldest first

    // Private copy of the blit registers and of the rectangle position.
    logic [CFG_DATA_W-1:0] blit_regs [8];
    logic [CNT_W-1:0]      col_pos;
    logic [CNT_W-1:0]      row_pos;

    // Register values last written by the stimulus, used to size the phases.
    logic [CFG_DATA_W-1:0] reg_plan [8];

    // Handshakes seen at the last rising edge, for the falling-edge drivers.
    logic s_fire   = 1'b0;
    logic cfg_fire = 1'b0;

    int pixels_taken   = 0;
    int pixels_checked = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    // While quiet_stretch is high both sides skip their random idling.
    logic quiet_stretch;
    assign quiet_stretch = (cycle_count % 2048) < 400;

    // ------------------------------------------------------------------------
    // Format and size rules. A format of 0 acts as gray, 5..7 act as RGBA;
    // sizes of 0 act as 1 and sizes beyond MAX_DIM are clamped.
    // ------------------------------------------------------------------------
    function automatic logic [FMT_W-1:0] fmt_of(input logic [CFG_DATA_W-1:0] v);
        logic [FMT_W-1:0] f;
        f = v[FMT_W-1:0];
        if (f == '0) return FMT_GRAY;
        if (f > FMT_RGBA) return FMT_RGBA;
        return f;
    endfunction

    function automatic logic [DIM_W-1:0] dim_of(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) return DIM_W'(1);
        if (v > CFG_DATA_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
        return DIM_W'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: converts one accepted pixel, works out its destination
    // address and flags, queues the result and advances the position.
    // ------------------------------------------------------------------------
    task automatic convert_pixel(input pixel_t px);
        logic [FMT_W-1:0]  sf;
        logic [FMT_W-1:0]  df;
        logic [DIM_W-1:0]  rw;
        logic [DIM_W-1:0]  rh;
        logic [DIM_W-1:0]  dw;
        logic [DIM_W-1:0]  dh;
        logic [DIM_W-1:0]  x;
        logic [DIM_W-1:0]  y;
        logic [9:0]        sum;
        logic [CHAN_W-1:0] gray;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [63:0]       linear;
        logic              end_row;
        converted_t        res;

        sf = fmt_of(blit_regs[REG_SRC_FORMAT]);
        df = fmt_of(blit_regs[REG_DST_FORMAT]);
        rw = dim_of(blit_regs[REG_RECT_WIDTH]);
        rh = dim_of(blit_regs[REG_RECT_HEIGHT]);
        dw = dim_of(blit_regs[REG_DEST_WIDTH]);
        dh = dim_of(blit_regs[REG_DEST_HEIGHT]);

        // A color source averages its three channels into gray; a gray
        // source replicates its one channel into red, green and blue.
        if (sf >= FMT_RGB) begin
            sum   = 10'(px.c0) + 10'(px.c1) + 10'(px.c2);
            gray  = CHAN_W'(sum / 3);
            red   = px.c0;
            green = px.c1;
            blue  = px.c2;
        end else begin
            gray  = px.c0;
            red   = px.c0;
            green = px.c0;
            blue  = px.c0;
        end

        // Alpha comes from the source when it has one, else it is opaque.
        if (sf == FMT_GRAY_ALPHA) begin
            alpha = px.c1;
        end else if (sf == FMT_RGBA) begin
            alpha = px.c3;
        end else begin
            alpha = OPAQUE_ALPHA;
        end

        res = '0;
        case (df)
            FMT_GRAY: begin
                res.c0 = gray;
            end
            FMT_GRAY_ALPHA: begin
                res.c0 = gray;
                res.c1 = alpha;
            end
            FMT_RGB: begin
                res.c0 = red;
                res.c1 = green;
                res.c2 = blue;
            end
            default: begin
                res.c0 = red;
                res.c1 = green;
                res.c2 = blue;
                res.c3 = alpha;
            end
        endcase
        res.nbytes = df;

        // Destination coordinate; a pixel outside the image gets offset 0.
        x = DIM_W'(blit_regs[REG_DEST_COL]) + DIM_W'(col_pos);
        y = DIM_W'(blit_regs[REG_DEST_ROW]) + DIM_W'(row_pos);
        res.oob = (x >= dw) || (y >= dh);
        linear = (64'(y) * 64'(dw) + 64'(x)) * 64'(df);
        res.offset = res.oob ? '0 : linear[OFFSET_W-1:0];

        // A position at or past the last column or row closes it, which also
        // covers a rectangle that shrank under a partly sent one.
        end_row  = (int'(col_pos) + 1 >= int'(rw));
        res.last = end_row && (int'(row_pos) + 1 >= int'(rh));

        if (res.last) begin
            col_pos = '0;
            row_pos = '0;
        end else if (end_row) begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end

        converted_pixels.push_back(res);
    endtask

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic report_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("[%0t ns] error: %s", $realtime, msg);
        end
    endtask

    task automatic compare_converted(input converted_t got, input converted_t want);
        string       names [8];
        logic [31:0] g [8];
        logic [31:0] w [8];

        names = '{"dest_offset", "out_chan0", "out_chan1", "out_chan2",
                  "out_chan3", "out_bytes", "out_of_range", "last"};
        g = '{32'(got.offset), 32'(got.c0), 32'(got.c1), 32'(got.c2),
              32'(got.c3), 32'(got.nbytes), 32'(got.oob), 32'(got.last)};
        w = '{32'(want.offset), 32'(want.c0), 32'(want.c1), 32'(want.c2),
              32'(want.c3), 32'(want.nbytes), 32'(want.oob), 32'(want.last)};
        for (int i = 0; i < 8; i++) begin
            if (g[i] !== w[i]) begin
                report_error($sformatf("result %0d %s: got %0h, expected %0h",
                                       pixels_checked, names[i], g[i], w[i]));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: samples both handshakes and the register port at the rising
    // edge, keeps the predictor in step and checks the results.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        converted_t got;
        converted_t want;

        if (!aresetn) begin
            s_fire   <= 1'b0;
            cfg_fire <= 1'b0;
            col_pos = '0;
            row_pos = '0;
            blit_regs[REG_SRC_FORMAT]  = CFG_DATA_W'(FMT_RGBA);
            blit_regs[REG_DST_FORMAT]  = CFG_DATA_W'(FMT_RGBA);
            blit_regs[REG_RECT_WIDTH]  = CFG_DATA_W'(1);
            blit_regs[REG_RECT_HEIGHT] = CFG_DATA_W'(1);
            blit_regs[REG_DEST_COL]    = '0;
            blit_regs[REG_DEST_ROW]    = '0;
            blit_regs[REG_DEST_WIDTH]  = CFG_DATA_W'(1);
            blit_regs[REG_DEST_HEIGHT] = CFG_DATA_W'(1);
        end else begin
            s_fire   <= s_valid && s_ready;
            cfg_fire <= cfg_valid && cfg_ready;

            // Each register keeps only as many bits as it has.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SRC_FORMAT, REG_DST_FORMAT:
                        blit_regs[cfg_index] = CFG_DATA_W'(cfg_data[FMT_W-1:0]);
                    REG_DEST_COL, REG_DEST_ROW:
                        blit_regs[cfg_index] = CFG_DATA_W'(cfg_data[CNT_W-1:0]);
                    default:
                        blit_regs[cfg_index] = cfg_data;
                endcase
            end

            if (s_valid && s_ready) begin
                convert_pixel({s_chan0, s_chan1, s_chan2, s_chan3});
                pixels_taken <= pixels_taken + 1;
            end

            if (m_valid && m_ready) begin
                got = {m_dest_offset, m_out_chan0, m_out_chan1, m_out_chan2,
                       m_out_chan3, m_out_bytes, m_out_of_range, m_last};
                if (converted_pixels.size() == 0) begin
                    report_error("result with no pixel pending");
                end else begin
                    want = converted_pixels.pop_front();
                    compare_converted(got, want);
                end
                pixels_checked <= pixels_checked + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: at the falling edge, moves on to the next pixel once the
    // current one has been taken, idling at random between pixels, and
    // stalls the result side at random.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : driver
        pixel_t px;

        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
            if (!s_valid || s_fire) begin
                if (source_pixels.size() != 0 &&
                    (quiet_stretch || $urandom_range(99) >= IDLE_PCT)) begin
                    px = source_pixels.pop_front();
                    s_valid <= 1'b1;
                    s_chan0 <= px.c0;
                    s_chan1 <= px.c1;
                    s_chan2 <= px.c2;
                    s_chan3 <= px.c3;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Cycle counter and run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // One register write, started at a falling edge and held until taken.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        reg_plan[idx] = val;
        do @(negedge aclk); while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued pixel is in and every result is out, then
    // lets the pipeline settle.
    task automatic wait_idle();
        do @(posedge aclk);
        while (source_pixels.size() != 0 || s_valid || pixels_taken != pixels_checked);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Random pixel with channels forced to 0x00 or 0xFF now and then.
    function automatic pixel_t random_pixel();
        logic [31:0] w;
        w = $urandom;
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(7) == 0) begin
                w[8*i +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
            end
        end
        return w;
    endfunction

    // Size register value: mostly modest, sometimes zero, the maximum,
    // past the maximum or anywhere in between.
    function automatic logic [CFG_DATA_W-1:0] random_dim(input int typical);
        case ($urandom_range(24))
            0:       return '0;
            1:       return CFG_DATA_W'(MAX_DIM);
            2:       return CFG_DATA_W'($urandom_range(8191, MAX_DIM + 1));
            3:       return CFG_DATA_W'($urandom_range(MAX_DIM, typical + 1));
            default: return CFG_DATA_W'($urandom_range(typical, 1));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_reg(input logic [CFG_IDX_W-1:0] idx);
        case (idx)
            REG_SRC_FORMAT, REG_DST_FORMAT:
                // Mostly legal formats; sometimes any 13-bit value.
                return ($urandom_range(6) == 0) ? CFG_DATA_W'($urandom)
                                                : CFG_DATA_W'($urandom_range(4, 1));
            REG_RECT_WIDTH, REG_RECT_HEIGHT:
                return random_dim(8);
            REG_DEST_WIDTH, REG_DEST_HEIGHT:
                return random_dim(48);
            default: begin
                // Origin: near the corner mostly, so that rectangles both
                // fit and spill over the image edge.
                case ($urandom_range(9))
                    0:       return CFG_DATA_W'($urandom_range(8191));
                    1:       return CFG_DATA_W'(MAX_DIM - 1);
                    2, 3:    return CFG_DATA_W'($urandom_range(40));
                    default: return CFG_DATA_W'($urandom_range(4));
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        int n;
        int area;
        int random_sent;

        random_sent = 0;
        reg_plan[REG_SRC_FORMAT]  = CFG_DATA_W'(FMT_RGBA);
        reg_plan[REG_DST_FORMAT]  = CFG_DATA_W'(FMT_RGBA);
        reg_plan[REG_RECT_WIDTH]  = CFG_DATA_W'(1);
        reg_plan[REG_RECT_HEIGHT] = CFG_DATA_W'(1);
        reg_plan[REG_DEST_COL]    = '0;
        reg_plan[REG_DEST_ROW]    = '0;
        reg_plan[REG_DEST_WIDTH]  = CFG_DATA_W'(1);
        reg_plan[REG_DEST_HEIGHT] = CFG_DATA_W'(1);

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Register defaults: RGBA copy of 1x1 rectangles, all-zero and
        // all-one pixels.
        @(posedge aclk);
        source_pixels.push_back('0);
        source_pixels.push_back('1);
        wait_idle();

        // Every pair of legal formats on a 3x2 rectangle inside an 8x8 image.
        // The first pattern averages to 254.67 and must round down to 254.
        write_reg(REG_RECT_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_RECT_HEIGHT, CFG_DATA_W'(2));
        write_reg(REG_DEST_COL, CFG_DATA_W'(1));
        write_reg(REG_DEST_ROW, CFG_DATA_W'(1));
        write_reg(REG_DEST_WIDTH, CFG_DATA_W'(8));
        write_reg(REG_DEST_HEIGHT, CFG_DATA_W'(8));
        for (int sf = FMT_GRAY; sf <= FMT_RGBA; sf++) begin
            for (int df = FMT_GRAY; df <= FMT_RGBA; df++) begin
                write_reg(REG_SRC_FORMAT, CFG_DATA_W'(sf));
                write_reg(REG_DST_FORMAT, CFG_DATA_W'(df));
                @(posedge aclk);
                case ((sf + df) % 3)
                    0:       source_pixels.push_back(32'hFFFF_FE7F);
                    1:       source_pixels.push_back(32'h0100_0180);
                    default: source_pixels.push_back(random_pixel());
                endcase
                wait_idle();
            end
        end

        // Illegal format codes, with upper data bits set that the block drops.
        write_reg(REG_SRC_FORMAT, '0);
        write_reg(REG_DST_FORMAT, 13'h1FFF);
        @(posedge aclk);
        source_pixels.push_back(random_pixel());
        wait_idle();
        write_reg(REG_SRC_FORMAT, 13'h1FFF);
        write_reg(REG_DST_FORMAT, 13'h1FF8);
        @(posedge aclk);
        source_pixels.push_back(random_pixel());
        wait_idle();

        // Size extremes. The position is back at the corner here, so the
        // first pixel lands on the final pixel of a 4096x4096 RGBA image and the
        // second falls below it. A narrower image then pushes the third off
        // the right edge alone.
        write_reg(REG_SRC_FORMAT, CFG_DATA_W'(FMT_RGBA));
        write_reg(REG_DST_FORMAT, CFG_DATA_W'(FMT_RGBA));
        write_reg(REG_RECT_WIDTH, '0);
        write_reg(REG_RECT_HEIGHT, 13'h1FFF);
        write_reg(REG_DEST_COL, 13'h1FFF);
        write_reg(REG_DEST_ROW, CFG_DATA_W'(MAX_DIM - 1));
        write_reg(REG_DEST_WIDTH, CFG_DATA_W'(MAX_DIM));
        write_reg(REG_DEST_HEIGHT, 13'h1FFF);
        @(posedge aclk);
        source_pixels.push_back(random_pixel());
        source_pixels.push_back(random_pixel());
        wait_idle();
        write_reg(REG_DEST_WIDTH, CFG_DATA_W'(MAX_DIM - 1));
        write_reg(REG_DEST_ROW, '0);
        @(posedge aclk);
        source_pixels.push_back(random_pixel());
        wait_idle();

        // Random phases: rewrite some registers, then send either whole
        // rectangles or a stray count that leaves the next setting to start
        // mid-rectangle.
        while (random_sent < RANDOM_ITEMS) begin
            for (int r = 0; r < 8; r++) begin
                if ($urandom_range(9) < 7) begin
                    write_reg(CFG_IDX_W'(r), random_reg(CFG_IDX_W'(r)));
                end
            end
            area = int'(dim_of(reg_plan[REG_RECT_WIDTH])) *
                   int'(dim_of(reg_plan[REG_RECT_HEIGHT]));
            if ($urandom_range(9) < 7 && area <= 96) begin
                n = area * $urandom_range(3, 1);
            end else begin
                n = $urandom_range(48, 1);
            end
            @(posedge aclk);
            repeat (n) source_pixels.push_back(random_pixel());
            random_sent += n;
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/pfb_pkg.sv
sv/pfb_front.sv
sv/pfb_queue.sv
sv/pfb_back.sv
sv/pixel_format_blit.sv
tb/testbench.sv
